// ----- src/vmdt_pkg.sv -----
// ----------------------------------------------------------------------------
// vmdt_pkg
// Types, constants and helpers shared by the vibration motor duty controller.
// ----------------------------------------------------------------------------
package vmdt_pkg;

  localparam int unsigned DutyW      = 8;
  localparam int unsigned TimeW      = 24;
  localparam int unsigned ElapsedW   = 16;
  localparam int unsigned PctW       = 7;
  localparam int unsigned CntW       = 4;
  localparam int unsigned ChannelsMax = 2;
  localparam int unsigned ChanW      = 1;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;

  localparam int unsigned DefChannels    = 2;
  localparam int unsigned DefResendTimes = 3;

  // floor(x / 100) == (x * 5243) >> 19 for x below 2^15
  localparam int unsigned Recip      = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned KW         = 20;
  localparam int unsigned ProdW      = DutyW + KW;
  localparam int unsigned QuotW      = ProdW - RecipShift;

  localparam logic [PctW-1:0]  PctReset  = PctW'(100);
  localparam logic [DutyW-1:0] DutyMax   = '1;

  localparam logic OpSet  = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [CfgIdxW-1:0] RegEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPercent0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinDuty0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPercent1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinDuty1 = 3'd4;

  typedef struct packed {
    logic                op;
    logic [ChanW-1:0]    channel;
    logic [DutyW-1:0]    duty;
    logic [TimeW-1:0]    run_ms;
    logic [ElapsedW-1:0] elapsed_ms;
  } vmdt_in_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_out_0;
    logic [DutyW-1:0] duty_out_1;
    logic             update_strobe;
  } vmdt_out_t;

  typedef struct packed {
    logic [KW-1:0]    scale_k;
    logic [DutyW-1:0] min_duty;
  } vmdt_chan_cfg_t;

  function automatic logic [KW-1:0] pct_to_k(logic [PctW-1:0] pct);
    return KW'(pct) * KW'(Recip);
  endfunction

endpackage

// ----- src/vibration_motor_duty_timeout.sv -----
// ----------------------------------------------------------------------------
// vibration_motor_duty_timeout
// Vibration motor duty controller with per-channel run timeout.
// ----------------------------------------------------------------------------
// Each request is a set command or a millisecond tick and yields exactly one
// result with both applied duties and the update strobe. A request is taken
// into an input register, worked out against the channel state and written
// to the result register, so one request is accepted every clock while the
// result register is free or its result is taken. While a finished result
// waits downstream the input register holds one further request; after that
// the input is stalled until the result is taken.
// Configuration writes take effect at once and must be made while idle.
module vibration_motor_duty_timeout import vmdt_pkg::*; #(
  parameter int unsigned CHANNELS     = DefChannels,
  parameter int unsigned RESEND_TIMES = DefResendTimes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vmdt_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vmdt_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [CntW-1:0] ResendLoad = CntW'(RESEND_TIMES);

  logic                 enable_q;
  logic [KW-1:0]        scale_k_q [ChannelsMax];
  logic [DutyW-1:0]     min_duty_q [ChannelsMax];

  logic                 s1_valid_q;
  vmdt_in_t             s1_item_q;
  logic                 out_valid_q;
  vmdt_out_t            out_data_q, out_data_d;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_eff;

  logic                 out_free;
  logic                 advance;
  logic                 accept;
  logic                 reload_any;
  logic [DutyW-1:0]     chan_duty [ChannelsMax];
  logic [ChannelsMax-1:0] chan_reload;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      for (int i = 0; i < ChannelsMax; i++) begin
        scale_k_q[i]  <= pct_to_k(PctReset);
        min_duty_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEnable:   enable_q      <= cfg_wdata_i[0];
        RegPercent0: scale_k_q[0]  <= pct_to_k(cfg_wdata_i[PctW-1:0]);
        RegMinDuty0: min_duty_q[0] <= cfg_wdata_i;
        RegPercent1: scale_k_q[1]  <= pct_to_k(cfg_wdata_i[PctW-1:0]);
        RegMinDuty1: min_duty_q[1] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
  end

  // channels
  for (genvar g = 0; g < ChannelsMax; g++) begin : g_chan
    if (g < CHANNELS) begin : g_used
      vmdt_chan_cfg_t ccfg;
      assign ccfg.scale_k  = scale_k_q[g];
      assign ccfg.min_duty = min_duty_q[g];

      vmdt_chan #(
        .Idx(g)
      ) u_chan (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .fire_i   (advance),
        .item_i   (s1_item_q),
        .enable_i (enable_q),
        .cfg_i    (ccfg),
        .duty_d_o (chan_duty[g]),
        .reload_o (chan_reload[g])
      );
    end else begin : g_unused
      assign chan_duty[g]   = '0;
      assign chan_reload[g] = 1'b0;
    end
  end

  // resend counter and result
  assign reload_any = |chan_reload;

  always_comb begin
    cnt_eff = reload_any ? ResendLoad : cnt_q;
    cnt_d   = cnt_eff;
    out_data_d.duty_out_0    = chan_duty[0];
    out_data_d.duty_out_1    = chan_duty[1];
    out_data_d.update_strobe = 1'b0;
    if (s1_item_q.op == OpTick && cnt_eff != '0) begin
      out_data_d.update_strobe = 1'b1;
      cnt_d = cnt_eff - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        cnt_q <= cnt_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/vmdt_chan.sv -----
// ----------------------------------------------------------------------------
// vmdt_chan
// One motor channel: duty scaling, duty and timeout state, expiry on ticks.
// ----------------------------------------------------------------------------
module vmdt_chan import vmdt_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  vmdt_in_t             item_i,
  input  logic                 enable_i,
  input  vmdt_chan_cfg_t       cfg_i,
  output logic [DutyW-1:0]     duty_d_o,
  output logic                 reload_o
);

  localparam logic [ChanW-1:0] ChanIdx = ChanW'(Idx);

  logic [DutyW-1:0]    duty_q, duty_d;
  logic [TimeW-1:0]    time_q, time_d;
  logic [DutyW-1:0]    raw;
  logic [ProdW-1:0]    prod;
  logic [QuotW-1:0]    quot;
  logic [DutyW-1:0]    sat;
  logic [DutyW-1:0]    new_duty;
  logic [TimeW-1:0]    dt;
  logic [TimeW-1:0]    rem;

  always_comb begin
    raw  = enable_i ? item_i.duty : '0;
    prod = ProdW'(raw) * ProdW'(cfg_i.scale_k);
    quot = prod[ProdW-1:RecipShift];
    sat  = (quot > QuotW'(DutyMax)) ? DutyMax : quot[DutyW-1:0];
    if (raw == '0 || cfg_i.scale_k == '0) begin
      new_duty = '0;
    end else if (sat < cfg_i.min_duty) begin
      new_duty = cfg_i.min_duty;
    end else begin
      new_duty = sat;
    end
  end

  always_comb begin
    dt       = TimeW'(item_i.elapsed_ms);
    rem      = time_q - dt;
    duty_d   = duty_q;
    time_d   = time_q;
    reload_o = 1'b0;
    if (item_i.op == OpSet) begin
      if (item_i.channel == ChanIdx) begin
        time_d = item_i.run_ms;
        if (duty_q != '0 || new_duty != '0) begin
          duty_d   = new_duty;
          reload_o = 1'b1;
        end
      end
    end else if (time_q > dt) begin
      if (rem < dt) begin
        time_d   = '0;
        duty_d   = '0;
        reload_o = 1'b1;
      end else begin
        time_d = rem;
      end
    end
  end

  assign duty_d_o = duty_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      time_q <= '0;
    end else if (fire_i) begin
      duty_q <= duty_d;
      time_q <= time_d;
    end
  end

endmodule
